### rtl/cir_pkg.sv
// shared constants, types and helpers of the collision impulse resolver
package cir_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int BOUNCE_FRAC = 8;
  localparam int COMP_W      = 16;
  localparam int VEC_W       = 3 * COMP_W;
  localparam int MASS_W      = 16;
  localparam int BOUNCE_W    = 9;

  // long divider sizes, common to every divider instance: quotient bits are produced one per stage
  localparam int DIV_NUM_W = 49;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_Q_W   = 19;

  // pipeline stage map
  localparam int ST_DIV1_IN  = 5;
  localparam int ST_DIV1_OUT = ST_DIV1_IN + DIV_Q_W;
  localparam int ST_PROJ     = ST_DIV1_OUT + 1;
  localparam int ST_SCALE    = ST_PROJ + 1;
  localparam int ST_MASS     = ST_SCALE + 1;
  localparam int ST_DIV2_IN  = ST_MASS + 1;
  localparam int PIPE_DEPTH  = ST_DIV2_IN + DIV_Q_W;

  typedef logic [2:0][COMP_W-1:0] vec_t;

  typedef struct packed {
    logic                  sa;
    logic                  sb;
    vec_t                  v;
    vec_t                  a;
    vec_t                  b;
    logic [MASS_W-1:0]     ma;
    logic [MASS_W-1:0]     mb;
    logic [MASS_W:0]       msum;
    logic [BOUNCE_W:0]     k;
    logic                  vvz;
    logic [2:0]            neg1;
    logic [2:0]            nega;
    logic [2:0]            negb;
    vec_t                  sr;
  } ctx_t;

  function automatic logic [COMP_W-1:0] sat16(input logic signed [39:0] x);
    logic [COMP_W-1:0] r;
    if (x > 40'sd32767) r = 16'h7fff;
    else if (x < -40'sd32768) r = 16'h8000;
    else r = x[COMP_W-1:0];
    return r;
  endfunction

endpackage

### rtl/cir_if.sv
// request channels of the collision impulse resolver
interface cir_pair_if;
  logic                          valid;
  logic                          ready;
  logic [cir_pkg::VEC_W-1:0]     overlap_vector;
  logic [cir_pkg::MASS_W-1:0]    mass_first;
  logic [cir_pkg::MASS_W-1:0]    mass_second;
  logic [cir_pkg::VEC_W-1:0]     velocity_first;
  logic [cir_pkg::VEC_W-1:0]     velocity_second;
  logic [cir_pkg::BOUNCE_W-1:0]  bounce_first;
  logic [cir_pkg::BOUNCE_W-1:0]  bounce_second;
  logic [1:0]                    static_flags;

  modport source (output valid, overlap_vector, mass_first, mass_second, velocity_first,
                  velocity_second, bounce_first, bounce_second, static_flags, input ready);
  modport sink (input valid, overlap_vector, mass_first, mass_second, velocity_first,
                velocity_second, bounce_first, bounce_second, static_flags, output ready);
endinterface

interface cir_result_if;
  logic                      valid;
  logic                      ready;
  logic [cir_pkg::VEC_W-1:0] new_velocity_first;
  logic [cir_pkg::VEC_W-1:0] new_velocity_second;
  logic [cir_pkg::VEC_W-1:0] offset_first;
  logic [cir_pkg::VEC_W-1:0] offset_second;
  logic                      pair_skipped;

  modport source (output valid, new_velocity_first, new_velocity_second, offset_first,
                  offset_second, pair_skipped, input ready);
  modport sink (input valid, new_velocity_first, new_velocity_second, offset_first,
                offset_second, pair_skipped, output ready);
endinterface

### rtl/cir_div.sv
// pipelined restoring divider, one quotient bit per stage
module cir_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cir_pkg::DIV_NUM_W-1:0] num,
  input  logic [cir_pkg::DIV_DEN_W-1:0] den,
  output logic [cir_pkg::DIV_Q_W-1:0]   quo
);

  localparam int NW = cir_pkg::DIV_NUM_W;
  localparam int DW = cir_pkg::DIV_DEN_W;
  localparam int QW = cir_pkg::DIV_Q_W;

  logic [DW-1:0] rem_q [1:QW-1];
  logic [QW-1:0] num_q [1:QW-1];
  logic [DW-1:0] den_q [1:QW-1];
  logic [QW-1:0] quo_q [1:QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [DW-1:0] r_in;
    logic [QW-1:0] n_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   trial;
    logic          take;

    if (s == 0) begin : g_first
      // quotient fits in QW bits, so the upper dividend part is below the divisor
      assign r_in = DW'(num[NW-1:QW]);
      assign n_in = num[QW-1:0];
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[s];
      assign n_in = num_q[s];
      assign d_in = den_q[s];
      assign q_in = quo_q[s];
    end

    assign trial = {r_in, n_in[QW-1-s]};
    assign take  = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[s+1] <= {q_in[QW-2:0], take};
      end
    end

    // the last step only delivers the quotient
    if (s < QW-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[s+1] <= take ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
          num_q[s+1] <= n_in;
          den_q[s+1] <= d_in;
        end
      end
    end
  end

  assign quo = quo_q[QW];

endmodule

### rtl/collision_impulse_resolver_unit.sv
// top level: impulse-based collision response for one pair per cycle
// an accepted pair moves through every context stage and then into the output register
// throughput: one pair per cycle; a stalled output freezes the whole pipeline in place
// the two banks of 19-stage long dividers (projection, impulse) set the depth
// reset: synchronous, clears all valid bits and the output valid; payload is not reset
module collision_impulse_resolver_unit (
  input  logic                clk,
  input  logic                rst,
  cir_pair_if.sink            pair,
  cir_result_if.source        result
);

  localparam int D = cir_pkg::PIPE_DEPTH;

  // whole pipeline advances together whenever the output register can take a result
  logic adv;
  assign adv        = !result.valid || result.ready;
  assign pair.ready = adv;

  // vld[s-1] travels with ctx[s]
  logic [D-1:0]      vld;
  cir_pkg::ctx_t     ctx      [1:D];
  cir_pkg::ctx_t     ctx_next [1:D];
  cir_pkg::ctx_t     ctx_in;

  // stage 1: unpack, pick the vector to project, restitution factor
  logic signed [16:0] u_c [3];
  logic signed [16:0] u1  [3];

  always_comb begin
    logic [cir_pkg::BOUNCE_W-1:0] emin;
    emin = (pair.bounce_first < pair.bounce_second) ? pair.bounce_first : pair.bounce_second;
    ctx_in      = '0;
    ctx_in.sa   = pair.static_flags[0];
    ctx_in.sb   = pair.static_flags[1];
    ctx_in.v    = pair.overlap_vector;
    ctx_in.a    = pair.velocity_first;
    ctx_in.b    = pair.velocity_second;
    ctx_in.ma   = pair.mass_first;
    ctx_in.mb   = pair.mass_second;
    ctx_in.msum = {1'b0, pair.mass_first} + {1'b0, pair.mass_second};
    ctx_in.k    = (cir_pkg::BOUNCE_W+1)'(1 << cir_pkg::BOUNCE_FRAC) + {1'b0, emin};
    for (int i = 0; i < 3; i++) begin
      // first static: project second velocity; second static: first; else relative
      if (pair.static_flags[0])
        u_c[i] = 17'($signed(ctx_in.b[i]));
      else if (pair.static_flags[1])
        u_c[i] = 17'($signed(ctx_in.a[i]));
      else
        u_c[i] = 17'($signed(ctx_in.a[i])) - 17'($signed(ctx_in.b[i]));
    end
  end

  // stage 2: component products for u.v and v.v
  logic signed [32:0] puv_c [3];
  logic signed [31:0] sq_c  [3];
  logic signed [32:0] puv2  [3];
  logic        [30:0] pvv2  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      puv_c[i] = u1[i] * $signed(ctx[1].v[i]);
      sq_c[i]  = $signed(ctx[1].v[i]) * $signed(ctx[1].v[i]);
    end
  end

  // stage 3: dot product sums
  logic signed [34:0] d_c;
  logic        [31:0] vv_c;
  logic signed [34:0] d3;
  logic        [31:0] vv3;

  assign d_c  = 35'(puv2[0]) + 35'(puv2[1]) + 35'(puv2[2]);
  assign vv_c = 32'(pvv2[0]) + 32'(pvv2[1]) + 32'(pvv2[2]);

  // stage 4: v_i times the dot product
  logic signed [50:0] pv_c [3];
  logic signed [50:0] pv4  [3];
  logic        [31:0] vv4;

  always_comb begin
    for (int i = 0; i < 3; i++) pv_c[i] = $signed(ctx[3].v[i]) * d3;
  end

  // stage 5: magnitudes into the projection divider
  logic [cir_pkg::DIV_NUM_W-1:0] mag_c [3];
  logic [cir_pkg::DIV_NUM_W-1:0] mag5  [3];
  logic [31:0]                   vv5;

  always_comb begin
    for (int i = 0; i < 3; i++)
      mag_c[i] = pv4[i][50] ? cir_pkg::DIV_NUM_W'(-pv4[i]) : cir_pkg::DIV_NUM_W'(pv4[i]);
  end

  logic [cir_pkg::DIV_Q_W-1:0] q1  [3];
  logic [cir_pkg::DIV_Q_W-1:0] q2a [3];
  logic [cir_pkg::DIV_Q_W-1:0] q2b [3];

  for (genvar i = 0; i < 3; i++) begin : g_proj
    cir_div u_div (.clk(clk), .en(adv), .num(mag5[i]), .den(vv5), .quo(q1[i]));
  end

  // projection stage: signed projection, zero for a zero-length normal
  logic signed [17:0] p_c  [3];
  logic signed [17:0] p25  [3];

  always_comb begin
    logic signed [17:0] qs;
    for (int i = 0; i < 3; i++) begin
      qs = $signed(18'(q1[i]));
      if (ctx[cir_pkg::ST_DIV1_OUT].vvz) p_c[i] = '0;
      else if (ctx[cir_pkg::ST_DIV1_OUT].neg1[i]) p_c[i] = -qs;
      else p_c[i] = qs;
    end
  end

  // scale stage: projection times restitution, and times mass of the moving body
  logic signed [28:0] t_c  [3];
  logic signed [34:0] sm_c [3];
  logic signed [28:0] t26  [3];
  logic signed [34:0] sm26 [3];

  always_comb begin
    logic [cir_pkg::MASS_W-1:0] ms;
    ms = ctx[cir_pkg::ST_PROJ].sa ? ctx[cir_pkg::ST_PROJ].mb : ctx[cir_pkg::ST_PROJ].ma;
    for (int i = 0; i < 3; i++) begin
      t_c[i]  = p25[i] * $signed({1'b0, ctx[cir_pkg::ST_PROJ].k});
      sm_c[i] = p25[i] * $signed({1'b0, ms});
    end
  end

  // mass stage: impulse numerators, and the finished velocity for the static cases
  logic signed [45:0] ta_c [3];
  logic signed [45:0] tb_c [3];
  logic signed [45:0] ta27 [3];
  logic signed [45:0] tb27 [3];
  cir_pkg::vec_t      sr_c;

  always_comb begin
    logic [33:0] smag;
    logic [33:0] sh;
    for (int i = 0; i < 3; i++) begin
      ta_c[i] = t26[i] * $signed({1'b0, ctx[cir_pkg::ST_SCALE].mb});
      tb_c[i] = t26[i] * $signed({1'b0, ctx[cir_pkg::ST_SCALE].ma});
      smag    = sm26[i][34] ? 34'(-sm26[i]) : 34'(sm26[i]);
      sh      = smag >> cir_pkg::FRAC_BITS;
      // negated, truncated toward zero
      sr_c[i] = sm26[i][34] ? cir_pkg::sat16(40'($signed({1'b0, sh})))
                            : cir_pkg::sat16(-40'($signed({1'b0, sh})));
    end
  end

  // impulse divider inputs: magnitudes with the bounce fraction dropped
  logic [cir_pkg::DIV_NUM_W-1:0] m2a_c [3];
  logic [cir_pkg::DIV_NUM_W-1:0] m2b_c [3];
  logic [cir_pkg::DIV_NUM_W-1:0] m2a   [3];
  logic [cir_pkg::DIV_NUM_W-1:0] m2b   [3];
  logic [cir_pkg::DIV_DEN_W-1:0] sden;

  always_comb begin
    logic [44:0] ma_mag;
    logic [44:0] mb_mag;
    for (int i = 0; i < 3; i++) begin
      ma_mag   = ta27[i][45] ? 45'(-ta27[i]) : 45'(ta27[i]);
      mb_mag   = tb27[i][45] ? 45'(-tb27[i]) : 45'(tb27[i]);
      m2a_c[i] = cir_pkg::DIV_NUM_W'(ma_mag >> cir_pkg::BOUNCE_FRAC);
      m2b_c[i] = cir_pkg::DIV_NUM_W'(mb_mag >> cir_pkg::BOUNCE_FRAC);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_imp
    cir_div u_diva (.clk(clk), .en(adv), .num(m2a[i]), .den(sden), .quo(q2a[i]));
    cir_div u_divb (.clk(clk), .en(adv), .num(m2b[i]), .den(sden), .quo(q2b[i]));
  end

  // context shift, with the fields filled in along the way
  always_comb begin
    ctx_next[1] = ctx_in;
    for (int s = 2; s <= D; s++) ctx_next[s] = ctx[s-1];
    ctx_next[3].vvz = (vv_c == '0);
    for (int i = 0; i < 3; i++) begin
      ctx_next[cir_pkg::ST_DIV1_IN].neg1[i] = pv4[i][50];
      ctx_next[cir_pkg::ST_DIV2_IN].nega[i] = ta27[i][45];
      ctx_next[cir_pkg::ST_DIV2_IN].negb[i] = tb27[i][45];
    end
    ctx_next[cir_pkg::ST_MASS].sr = sr_c;
  end

  // final: apply impulses or pick the static case, saturate, pack
  cir_pkg::vec_t na_c, nb_c, oa_c, ob_c;
  logic          skip_c;

  always_comb begin
    cir_pkg::ctx_t       c;
    logic signed [20:0]  qa, qb, ia, ib;
    logic signed [16:0]  vs, h;
    c      = ctx[D];
    skip_c = c.sa && c.sb;
    for (int i = 0; i < 3; i++) begin
      qa = $signed(21'(q2a[i]));
      qb = $signed(21'(q2b[i]));
      if (c.msum == '0) begin
        ia = '0;
        ib = '0;
      end else begin
        ia = c.nega[i] ? -qa : qa;
        ib = c.negb[i] ? -qb : qb;
      end
      vs = 17'($signed(c.v[i]));
      h  = (vs + (vs[16] ? 17'sd1 : 17'sd0)) >>> 1;
      case ({c.sb, c.sa})
        2'b11: begin
          na_c[i] = c.a[i];
          nb_c[i] = c.b[i];
          oa_c[i] = '0;
          ob_c[i] = '0;
        end
        2'b01: begin
          na_c[i] = c.a[i];
          nb_c[i] = c.sr[i];
          oa_c[i] = '0;
          ob_c[i] = c.v[i];
        end
        2'b10: begin
          na_c[i] = c.sr[i];
          nb_c[i] = c.b[i];
          oa_c[i] = cir_pkg::sat16(-40'(vs));
          ob_c[i] = '0;
        end
        default: begin
          na_c[i] = cir_pkg::sat16(40'($signed(c.a[i])) - 40'(ia));
          nb_c[i] = cir_pkg::sat16(40'($signed(c.b[i])) + 40'(ib));
          oa_c[i] = 16'(-h);
          ob_c[i] = 16'(h);
        end
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result.valid <= 1'b0;
    end else if (adv) begin
      vld          <= {vld[D-2:0], pair.valid};
      result.valid <= vld[D-1];
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 1; s <= D; s++) ctx[s] <= ctx_next[s];
      for (int i = 0; i < 3; i++) begin
        u1[i]   <= u_c[i];
        puv2[i] <= puv_c[i];
        pvv2[i] <= sq_c[i][30:0];
        pv4[i]  <= pv_c[i];
        mag5[i] <= mag_c[i];
        p25[i]  <= p_c[i];
        t26[i]  <= t_c[i];
        sm26[i] <= sm_c[i];
        ta27[i] <= ta_c[i];
        tb27[i] <= tb_c[i];
        m2a[i]  <= m2a_c[i];
        m2b[i]  <= m2b_c[i];
      end
      d3   <= d_c;
      vv3  <= vv_c;
      vv4  <= vv3;
      vv5  <= vv4;
      sden <= cir_pkg::DIV_DEN_W'(ctx[cir_pkg::ST_MASS].msum);
      result.new_velocity_first  <= na_c;
      result.new_velocity_second <= nb_c;
      result.offset_first        <= oa_c;
      result.offset_second       <= ob_c;
      result.pair_skipped        <= skip_c;
    end
  end

endmodule

### rtl/cir_checker.sv
// port-level checks of the collision impulse resolver, bound to the top level
module cir_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      pair_ready,
  input logic                      result_valid,
  input logic                      result_ready,
  input logic [cir_pkg::VEC_W-1:0] offset_first,
  input logic [cir_pkg::VEC_W-1:0] offset_second,
  input logic                      pair_skipped
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(offset_first) && $stable(offset_second))
    else $error("result payload changed while stalled");

  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !pair_ready)
    else $error("request taken while output stalled");

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && pair_skipped |-> offset_first == '0 && offset_second == '0)
    else $error("skipped pair with nonzero offset");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule

bind collision_impulse_resolver_unit cir_checker u_cir_checker (
  .clk          (clk),
  .rst          (rst),
  .pair_ready   (pair.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .offset_first (result.offset_first),
  .offset_second(result.offset_second),
  .pair_skipped (result.pair_skipped)
);
